FILE: src/tta_pkg.sv
`default_nettype none

package tta_pkg;

    // Configuration port geometry.
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 13;

    // Register field widths.
    localparam int RANK_W       = 3;
    localparam int DIM_REG_W    = 13;
    localparam int ORDER_W      = 8;
    localparam int AXIS_FIELD_W = 2;

    // Number of axis size registers and axis order fields on the port.
    localparam int CFG_DIMS = 4;

    // Width of the index fields on the result stream.
    localparam int OUT_IDX_W = 32;

    // Register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_RANK       = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_DIM0       = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_DIM1       = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_DIM2       = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_DIM3       = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_AXIS_ORDER = 3'd5;

    // Register reset values; the axis order resets to the identity 0,1,2,3.
    localparam logic [RANK_W-1:0]    RANK_RESET  = 3'd1;
    localparam logic [DIM_REG_W-1:0] DIM_RESET   = 13'd1;
    localparam logic [ORDER_W-1:0]   ORDER_RESET = 8'd228;

    // Configuration register set.
    typedef struct packed {
        logic [RANK_W-1:0]                   rank;
        logic [CFG_DIMS-1:0][DIM_REG_W-1:0]  dim_size;
        logic [ORDER_W-1:0]                  axis_order;
    } cfg_t;

    // Stride precompute sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_IN,
        ST_MUL,
        ST_ACC
    } stride_state_t;

endpackage

`default_nettype wire

FILE: src/tta_skid.sv
`default_nettype none

module tta_skid #(
    parameter int WIDTH = 65
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [WIDTH-1:0] in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [WIDTH-1:0]      out_data
);

    logic             out_valid_reg;
    logic             out_valid_next;
    logic             skid_valid_reg;
    logic             skid_valid_next;
    logic [WIDTH-1:0] out_data_reg;
    logic [WIDTH-1:0] out_data_next;
    logic [WIDTH-1:0] skid_data_reg;
    logic [WIDTH-1:0] skid_data_next;
    logic             in_fire;
    logic             out_free;

    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && !skid_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // The output register refills from the skid word first, else from the input.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = in_fire;
                out_data_next  = in_data;
            end
        end
        else if (in_fire)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

`default_nettype wire

FILE: src/tta_stride.sv
`default_nettype none

module tta_stride
    import tta_pkg::*;
#(
    parameter int MAX_DIMS   = 4,
    parameter int DIM_BITS   = 12,
    parameter int INDEX_BITS = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire cfg_t               cfg,
    output logic                    busy,
    output logic [MAX_DIMS-1:0]     active,
    output logic [DIM_BITS-1:0]     size_m1 [MAX_DIMS],
    output logic [INDEX_BITS-1:0]   delta [MAX_DIMS]
);

    localparam int CNT_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int SIZE_W = DIM_BITS + 1;
    localparam int CMP_W  = (DIM_REG_W > SIZE_W) ? DIM_REG_W : SIZE_W;
    localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(MAX_DIMS - 1);

    stride_state_t   state_reg;
    stride_state_t   state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    logic ld_init;
    logic ld_in;
    logic ld_mul;
    logic ld_acc;

    logic [INDEX_BITS-1:0] in_stride_reg [MAX_DIMS];
    logic [INDEX_BITS-1:0] acc_reg;
    logic [INDEX_BITS-1:0] wrap_reg;
    logic [INDEX_BITS-1:0] stride_k_reg;
    logic [INDEX_BITS-1:0] prod_reg;
    logic [DIM_BITS-1:0]   size_m1_reg [MAX_DIMS];
    logic [INDEX_BITS-1:0] delta_reg [MAX_DIMS];

    logic [CNT_W-1:0]      ax_cur;
    logic [SIZE_W-1:0]     dim_cur;
    logic [SIZE_W-1:0]     dim_ax;
    logic [SIZE_W-1:0]     dim_ax_m1;
    logic [INDEX_BITS-1:0] stride_ax;

    // Effective size of an input axis: zero reads as one, large values saturate.
    function automatic logic [SIZE_W-1:0] eff_dim(input logic [CNT_W-1:0] a);
        logic [CMP_W-1:0] v;
        logic [CMP_W-1:0] cap;
        v   = CMP_W'(1);
        cap = CMP_W'(1) << DIM_BITS;
        for (int j = 0; j < CFG_DIMS; j++)
        begin
            if (int'(a) == j)
            begin
                v = CMP_W'(cfg.dim_size[j]);
            end
        end
        if (v == '0)
        begin
            v = CMP_W'(1);
        end
        else if (v > cap)
        begin
            v = cap;
        end
        return SIZE_W'(v);
    endfunction

    // Input axis taken by output axis k, folded into the axis range.
    function automatic logic [CNT_W-1:0] axis_of(input logic [CNT_W-1:0] k);
        logic [AXIS_FIELD_W-1:0] f;
        f = '0;
        for (int j = 0; j < CFG_DIMS; j++)
        begin
            if (int'(k) == j)
            begin
                f = cfg.axis_order[AXIS_FIELD_W*j +: AXIS_FIELD_W];
            end
        end
        for (int j = 0; j < 3; j++)
        begin
            if (int'(f) >= MAX_DIMS)
            begin
                f = f - AXIS_FIELD_W'(MAX_DIMS);
            end
        end
        return CNT_W'(f);
    endfunction

    // Axes below the clamped rank are in use; axis zero always is.
    always_comb
    begin
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            active[d] = (d == 0) || (int'(cfg.rank) > d);
        end
    end

    // Next state: a pass over the input axes, then a multiply and an
    // accumulate step for each output axis, innermost first.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                state_next = ST_IDLE;
            end
            ST_INIT:
            begin
                state_next = ST_IN;
                cnt_next   = CNT_TOP;
            end
            ST_IN:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_MUL;
                    cnt_next   = CNT_TOP;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_MUL:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_MUL;
                    cnt_next   = cnt_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (start)
        begin
            state_next = ST_INIT;
        end
    end

    // Datapath enables decoded from the state.
    always_comb
    begin
        busy    = 1'b1;
        ld_init = 1'b0;
        ld_in   = 1'b0;
        ld_mul  = 1'b0;
        ld_acc  = 1'b0;
        unique case (state_reg)
            ST_IDLE: busy    = 1'b0;
            ST_INIT: ld_init = 1'b1;
            ST_IN:   ld_in   = 1'b1;
            ST_MUL:  ld_mul  = 1'b1;
            ST_ACC:  ld_acc  = 1'b1;
            default: busy    = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            cnt_reg   <= CNT_TOP;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Axis sizes and the axis selection for the current step.
    always_comb
    begin
        dim_cur = eff_dim(cnt_reg);
        ax_cur  = axis_of(cnt_reg);
        dim_ax  = eff_dim(ax_cur);
    end

    assign dim_ax_m1 = dim_ax - 1'b1;
    assign stride_ax = in_stride_reg[ax_cur];

    // Input strides come from a running product of the inner axis sizes.
    // The wrap sum collects (size - 1) * stride over the inner output axes.
    always_ff @(posedge clk)
    begin
        if (ld_init)
        begin
            acc_reg  <= INDEX_BITS'(1);
            wrap_reg <= '0;
        end
        if (ld_in)
        begin
            if (active[cnt_reg])
            begin
                in_stride_reg[cnt_reg] <= acc_reg;
                acc_reg <= INDEX_BITS'(acc_reg * INDEX_BITS'(dim_cur));
            end
            else
            begin
                in_stride_reg[cnt_reg] <= INDEX_BITS'(1);
            end
        end
        if (ld_mul)
        begin
            stride_k_reg         <= stride_ax;
            size_m1_reg[cnt_reg] <= DIM_BITS'(dim_ax_m1);
            prod_reg             <= INDEX_BITS'(stride_ax * INDEX_BITS'(dim_ax_m1));
        end
        if (ld_acc)
        begin
            delta_reg[cnt_reg] <= stride_k_reg - wrap_reg;
            if (active[cnt_reg])
            begin
                wrap_reg <= wrap_reg + prod_reg;
            end
        end
    end

    assign size_m1 = size_m1_reg;
    assign delta   = delta_reg;

endmodule

`default_nettype wire

FILE: src/tensor_transpose_address_gen.sv
`default_nettype none

// Address generator for an N-dimensional tensor permute. Each input word asks
// for the next element of the output tensor in row-major order and yields one
// result word with the source index to read, the destination index to write
// and tlast on the final element; after that element the walk wraps to zero,
// and a set restart bit returns it to element zero before the element is
// produced. One element is issued per clock while the output buffer has room
// and no precompute runs: the odometer step is a single compare per axis and
// one add of a precomputed per-axis offset delta, and each result is held in a
// two-word output buffer. Every write to a decoded configuration register
// returns the walk to element zero and starts a stride precompute: a start
// step, one step per input axis for the running stride product, and a multiply
// and an accumulate step per output axis; s_axis_tready stays low during it,
// and also during the same pass that follows reset.
module tensor_transpose_address_gen
    import tta_pkg::*;
#(
    parameter int MAX_DIMS   = 4,
    parameter int DIM_BITS   = 12,
    parameter int INDEX_BITS = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [7:0]            s_axis_tdata,   // [0] restart, [7:1] zero
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [2*OUT_IDX_W-1:0]     m_axis_tdata,   // [31:0] src_index, [63:32] dst_index
    output logic                       m_axis_tlast    // last
);

    localparam int RES_W = 2 * OUT_IDX_W + 1;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic cfg_hit;

    logic                  busy;
    logic [MAX_DIMS-1:0]   active;
    logic [DIM_BITS-1:0]   size_m1 [MAX_DIMS];
    logic [INDEX_BITS-1:0] delta [MAX_DIMS];

    logic [DIM_BITS-1:0]   coord_reg [MAX_DIMS];
    logic [DIM_BITS-1:0]   coord_next [MAX_DIMS];
    logic [DIM_BITS-1:0]   cur_coord [MAX_DIMS];
    logic [INDEX_BITS-1:0] src_reg;
    logic [INDEX_BITS-1:0] src_next;
    logic [INDEX_BITS-1:0] dst_reg;
    logic [INDEX_BITS-1:0] dst_next;
    logic [INDEX_BITS-1:0] cur_src;
    logic [INDEX_BITS-1:0] cur_dst;
    logic [INDEX_BITS-1:0] src_step;
    logic [MAX_DIMS-1:0]   at_max;
    logic [MAX_DIMS-1:0]   inner_max;
    logic                  run;
    logic                  last;
    logic                  restart;
    logic                  push;
    logic                  buf_in_ready;
    logic [RES_W-1:0]      res_word;
    logic [RES_W-1:0]      out_word;

    // Configuration register decode.
    always_comb
    begin
        cfg_next = cfg_reg;
        cfg_hit  = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_RANK:
                begin
                    cfg_next.rank = cfg_wdata[RANK_W-1:0];
                    cfg_hit       = 1'b1;
                end
                CFG_DIM0:
                begin
                    cfg_next.dim_size[0] = cfg_wdata[DIM_REG_W-1:0];
                    cfg_hit              = 1'b1;
                end
                CFG_DIM1:
                begin
                    cfg_next.dim_size[1] = cfg_wdata[DIM_REG_W-1:0];
                    cfg_hit              = 1'b1;
                end
                CFG_DIM2:
                begin
                    cfg_next.dim_size[2] = cfg_wdata[DIM_REG_W-1:0];
                    cfg_hit              = 1'b1;
                end
                CFG_DIM3:
                begin
                    cfg_next.dim_size[3] = cfg_wdata[DIM_REG_W-1:0];
                    cfg_hit              = 1'b1;
                end
                CFG_AXIS_ORDER:
                begin
                    cfg_next.axis_order = cfg_wdata[ORDER_W-1:0];
                    cfg_hit             = 1'b1;
                end
                default:
                begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rank       <= RANK_RESET;
            cfg_reg.dim_size   <= {CFG_DIMS{DIM_RESET}};
            cfg_reg.axis_order <= ORDER_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Stride and wrap offset precompute.
    tta_stride #(
        .MAX_DIMS   (MAX_DIMS),
        .DIM_BITS   (DIM_BITS),
        .INDEX_BITS (INDEX_BITS)
    ) u_stride (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cfg_hit),
        .cfg     (cfg_reg),
        .busy    (busy),
        .active  (active),
        .size_m1 (size_m1),
        .delta   (delta)
    );

    assign restart       = s_axis_tdata[0];
    assign s_axis_tready = buf_in_ready && !busy;
    assign push          = s_axis_tvalid && s_axis_tready;

    // Odometer step. An axis advances when every inner axis sits at its
    // maximum; those inner axes wrap, and the source offset moves by the
    // precomputed delta of the advancing axis.
    always_comb
    begin
        run      = 1'b1;
        src_step = '0;
        cur_src  = restart ? '0 : src_reg;
        cur_dst  = restart ? '0 : dst_reg;
        for (int d = MAX_DIMS - 1; d >= 0; d--)
        begin
            cur_coord[d] = restart ? '0 : coord_reg[d];
            at_max[d]    = !active[d] || (cur_coord[d] == size_m1[d]);
            inner_max[d] = run;
            run          = run && at_max[d];
        end
        last = run;
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            if (inner_max[d] && !at_max[d])
            begin
                coord_next[d] = cur_coord[d] + 1'b1;
                src_step      = src_step | delta[d];
            end
            else if (inner_max[d])
            begin
                coord_next[d] = '0;
            end
            else
            begin
                coord_next[d] = cur_coord[d];
            end
        end
        src_next = last ? '0 : cur_src + src_step;
        dst_next = last ? '0 : cur_dst + 1'b1;
    end

    // Walk state: cleared by reset and by every write to a decoded register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int d = 0; d < MAX_DIMS; d++)
            begin
                coord_reg[d] <= '0;
            end
            src_reg <= '0;
            dst_reg <= '0;
        end
        else if (cfg_hit)
        begin
            for (int d = 0; d < MAX_DIMS; d++)
            begin
                coord_reg[d] <= '0;
            end
            src_reg <= '0;
            dst_reg <= '0;
        end
        else if (push)
        begin
            coord_reg <= coord_next;
            src_reg   <= src_next;
            dst_reg   <= dst_next;
        end
    end

    // Result word into the output buffer.
    assign res_word = {last, OUT_IDX_W'(cur_dst), OUT_IDX_W'(cur_src)};

    tta_skid #(
        .WIDTH (RES_W)
    ) u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid && !busy),
        .in_ready  (buf_in_ready),
        .in_data   (res_word),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_word)
    );

    assign m_axis_tdata = out_word[2*OUT_IDX_W-1:0];
    assign m_axis_tlast = out_word[RES_W-1];

endmodule

`default_nettype wire

FILE: tb/transpose_addr_checker.sv
`timescale 1ns / 1ps

// Watches the configuration port and both streams of the transpose address
// generator, predicts every result word from the accepted input words and
// compares each result word with the oldest prediction.
module transpose_addr_checker
    import tta_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                   in_valid,
    input  wire logic                   in_ready,
    input  wire logic [7:0]             in_data,   // [0] restart, [7:1] zero
    input  wire logic                   out_valid,
    input  wire logic                   out_ready,
    input  wire logic [2*OUT_IDX_W-1:0] out_data,  // [31:0] src_index, [63:32] dst_index
    input  wire logic                   out_last,
    output int                          mismatches,
    output int                          pending
);

    localparam int NUM_AXES = CFG_DIMS;
    localparam int AXIS_CAP = 4096;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] src;
        logic [OUT_IDX_W-1:0] dst;
        logic                 is_last;
    } element_t;

    // Predicted result words, oldest first.
    element_t expected_elems[$];

    // Shadow copy of the configuration registers.
    logic [RANK_W-1:0]    rank_q;
    logic [DIM_REG_W-1:0] dim_q [NUM_AXES];
    logic [ORDER_W-1:0]   order_q;

    // Odometer over the output axes and the running indexes.
    int unsigned          coord    [NUM_AXES];
    int unsigned          axis_len [NUM_AXES];
    logic [31:0]          stride   [NUM_AXES];
    logic [31:0]          src_ofs;
    logic [31:0]          dst_cnt;

    // Rank of zero acts as one; anything above the axis count saturates.
    function automatic int unsigned active_rank();
        if (rank_q == 0)
            return 1;
        if (rank_q > NUM_AXES)
            return NUM_AXES;
        return rank_q;
    endfunction

    // Axis sizes of zero act as one; oversized axes saturate at the cap.
    function automatic int unsigned clamp_dim(input int unsigned a);
        int unsigned v;
        v = dim_q[a];
        if (v == 0)
            return 1;
        if (v > AXIS_CAP)
            return AXIS_CAP;
        return v;
    endfunction

    function automatic void rewind();
        for (int i = 0; i < NUM_AXES; i++)
            coord[i] = 0;
        src_ofs = '0;
        dst_cnt = '0;
    endfunction

    // Row-major strides of the input tensor, then gathered per output axis.
    // Axes beyond the rank get a stride of one.
    function automatic void derive_strides();
        logic [31:0] in_stride [NUM_AXES];
        logic [31:0] acc;
        int unsigned r;
        int unsigned ax;
        r = active_rank();
        acc = 32'd1;
        for (int k = NUM_AXES - 1; k >= 0; k--) begin
            if (k >= r) begin
                in_stride[k] = 32'd1;
            end
            else begin
                in_stride[k] = acc;
                acc = acc * 32'(clamp_dim(k));
            end
        end
        for (int i = 0; i < NUM_AXES; i++) begin
            ax = order_q[2*i +: AXIS_FIELD_W];
            stride[i]   = in_stride[ax];
            axis_len[i] = clamp_dim(ax);
        end
    endfunction

    // Produces the element for one request and steps the odometer.
    function automatic element_t advance(input logic restart);
        element_t    e;
        int unsigned r;
        logic        at_end;
        r = active_rank();
        if (restart)
            rewind();
        at_end = 1'b1;
        for (int d = 0; d < r; d++)
            if (coord[d] + 1 < axis_len[d])
                at_end = 1'b0;
        e.src     = src_ofs;
        e.dst     = dst_cnt;
        e.is_last = at_end;
        if (at_end) begin
            rewind();
        end
        else begin
            dst_cnt = dst_cnt + 32'd1;
            for (int d = r - 1; d >= 0; d--) begin
                coord[d] = coord[d] + 1;
                src_ofs  = src_ofs + stride[d];
                if (coord[d] < axis_len[d])
                    break;
                src_ofs  = src_ofs - 32'(coord[d]) * stride[d];
                coord[d] = 0;
            end
        end
        return e;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        element_t want;
        logic     known;
        if (!rst_n)
        begin
            rank_q  = RANK_RESET;
            for (int i = 0; i < NUM_AXES; i++)
                dim_q[i] = DIM_RESET;
            order_q = ORDER_RESET;
            rewind();
            derive_strides();
            expected_elems.delete();
            mismatches = 0;
            pending    = 0;
        end
        else
        begin
            // Compare an accepted result word with the oldest prediction.
            if (out_valid && out_ready)
            begin
                if (expected_elems.size() == 0)
                begin
                    $error("result word with nothing expected: src %0d dst %0d last %0b",
                           out_data[31:0], out_data[63:32], out_last);
                    mismatches++;
                end
                else
                begin
                    want = expected_elems.pop_front();
                    if (want.src !== out_data[31:0])
                    begin
                        $error("src_index: expected %0d, got %0d", want.src, out_data[31:0]);
                        mismatches++;
                    end
                    if (want.dst !== out_data[63:32])
                    begin
                        $error("dst_index: expected %0d, got %0d", want.dst, out_data[63:32]);
                        mismatches++;
                    end
                    if (want.is_last !== out_last)
                    begin
                        $error("last: expected %0b, got %0b", want.is_last, out_last);
                        mismatches++;
                    end
                end
            end

            // A write to a known register re-derives strides and rewinds the walk.
            if (cfg_we)
            begin
                known = 1'b1;
                case (cfg_addr)
                    CFG_RANK:       rank_q  = cfg_wdata[RANK_W-1:0];
                    CFG_DIM0, CFG_DIM1, CFG_DIM2, CFG_DIM3:
                                    dim_q[int'(cfg_addr - CFG_DIM0)] = cfg_wdata;
                    CFG_AXIS_ORDER: order_q = cfg_wdata[ORDER_W-1:0];
                    default:        known   = 1'b0;
                endcase
                if (known)
                begin
                    derive_strides();
                    rewind();
                end
            end

            // Every accepted request word yields exactly one element.
            if (in_valid && in_ready)
                expected_elems.push_back(advance(in_data[0]));

            pending = expected_elems.size();
        end
    end

endmodule

FILE: tb/tb_tensor_transpose_address_gen.sv
`timescale 1ns / 1ps

module tb_tensor_transpose_address_gen;
    import tta_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 300;
    localparam int RANDOM_WORDS   = 700;
    localparam int DRAIN_CYCLES   = 16;

    // Register indexes the block does not decode.
    localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED_A = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED_B = 3'd7;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_ADDR_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata;   // [0] restart, [7:1] zero
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [2*OUT_IDX_W-1:0] m_axis_tdata;   // [31:0] src_index, [63:32] dst_index
    logic                   m_axis_tlast;

    int   mismatches;
    int   pending;
    bit   tx_idle;
    bit   rx_idle;
    bit   long_hold_req;
    int   rx_hold;
    int   idle_cycles;
    int   words_sent;
    int   phase_no;

    tensor_transpose_address_gen DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    transpose_addr_checker addr_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_data    (s_axis_tdata),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (m_axis_tdata),
        .out_last   (m_axis_tlast),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always #4 clk = ~clk;

    // Result side: in idle phases a random stall after each accepted word, or one
    // long hold when the stimulus asks for it.
    initial
    begin
        m_axis_tready = 1'b0;
        rx_hold       = 0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                rx_hold       = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (rx_hold > 0)
            begin
                m_axis_tready <= 1'b0;
                rx_hold--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
            rx_hold = rx_idle ? $urandom_range(0, 7) : 0;
    end

    // Ends the run if neither stream nor the register port moves for too long.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Offers one request word (after a random gap if tx_idle) until it is taken.
    task automatic send_word(input logic restart);
        int gap;
        gap = tx_idle ? $urandom_range(0, 7) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, restart};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Stops offering and waits until every predicted word has come back.
    task automatic drain_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // One register write, then wait out the stride precompute.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        do
            @(negedge clk);
        while (!s_axis_tready);
    endtask

    // Mostly small axes so the walk wraps often; now and then a zero or an
    // oversized axis.
    function automatic logic [CFG_DATA_W-1:0] rand_dim();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return CFG_DATA_W'($urandom_range(4096, 8191));
        if (pick < 5)
            return CFG_DATA_W'($urandom_range(5, 8));
        return CFG_DATA_W'($urandom_range(1, 4));
    endfunction

    // Rewrites a random subset of the registers.
    task automatic apply_random_config();
        int                  p [4];
        int                  j;
        int                  t;
        logic [ORDER_W-1:0]  ord;
        logic [CFG_DATA_W-1:0] v;
        if ($urandom_range(0, 9) < 6)
        begin
            if ($urandom_range(0, 9) == 0)
                v = ($urandom_range(0, 3) == 0) ? '0 : CFG_DATA_W'($urandom_range(5, 7));
            else
                v = CFG_DATA_W'($urandom_range(1, 4));
            write_reg(CFG_RANK, v);
        end
        for (int k = 0; k < CFG_DIMS; k++)
            if ($urandom_range(0, 9) < 6)
                write_reg(CFG_DIM0 + CFG_ADDR_W'(k), rand_dim());
        if ($urandom_range(0, 9) < 6)
        begin
            // Mostly true permutations; otherwise any mix of axes.
            if ($urandom_range(0, 9) < 6)
            begin
                p = '{0, 1, 2, 3};
                for (j = 3; j > 0; j--)
                begin
                    t = $urandom_range(0, j);
                    {p[j], p[t]} = {p[t], p[j]};
                end
                ord = {p[3][1:0], p[2][1:0], p[1][1:0], p[0][1:0]};
            end
            else
            begin
                ord = ORDER_W'($urandom_range(0, 255));
            end
            write_reg(CFG_AXIS_ORDER, CFG_DATA_W'(ord));
        end
        if ($urandom_range(0, 9) == 0)
            write_reg($urandom_range(0, 1) ? CFG_UNUSED_A : CFG_UNUSED_B,
                      CFG_DATA_W'($urandom_range(0, 8191)));
    endtask

    task automatic run_words(input int n, input int restart_pct);
        for (int i = 0; i < n; i++)
            send_word($urandom_range(0, 99) < restart_pct);
    endtask

    // Picks which sides idle in the coming phase; some phases run flat out.
    task automatic t_modes();
        int mode;
        mode    = $urandom_range(0, 3);
        tx_idle = mode[0];
        rx_idle = mode[1];
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = CFG_RANK;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        tx_idle       = 1'b1;
        rx_idle       = 1'b1;
        long_hold_req = 1'b0;
        idle_cycles   = 0;
        words_sent    = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset configuration: a single element, last on every word.
        send_word(1'b0);
        send_word(1'b1);
        drain_results();

        // Two axes swapped, with a restart in the middle.
        write_reg(CFG_RANK, 2);
        write_reg(CFG_DIM0, 3);
        write_reg(CFG_DIM1, 2);
        write_reg(CFG_AXIS_ORDER, 225);
        send_word(1'b0);
        send_word(1'b0);
        send_word(1'b0);
        send_word(1'b1);
        send_word(1'b0);
        send_word(1'b0);
        send_word(1'b0);
        drain_results();

        // Rank of zero and a zero-sized axis both act as one.
        write_reg(CFG_RANK, 0);
        write_reg(CFG_DIM0, 0);
        send_word(1'b1);
        drain_results();

        // Rank above the axis count, oversized axes, every field naming axis 3.
        write_reg(CFG_RANK, 7);
        write_reg(CFG_DIM0, 2);
        write_reg(CFG_DIM2, 8191);
        write_reg(CFG_DIM3, 4097);
        write_reg(CFG_AXIS_ORDER, 255);
        send_word(1'b0);
        send_word(1'b0);
        send_word(1'b1);
        drain_results();

        // Writes to undecoded indexes leave the walk where it is.
        write_reg(CFG_UNUSED_A, 8191);
        write_reg(CFG_UNUSED_B, 0);
        send_word(1'b0);
        send_word(1'b0);
        drain_results();

        // Every output axis reads input axis 0: repeated reads, others unread.
        write_reg(CFG_RANK, 3);
        write_reg(CFG_DIM1, 3);
        write_reg(CFG_DIM2, 1);
        write_reg(CFG_AXIS_ORDER, 0);
        run_words(8, 0);

        // Random phases with a fresh configuration each time.
        phase_no = 0;
        while (words_sent < RANDOM_WORDS)
        begin
            drain_results();
            if (phase_no == 1)
            begin
                // Strides past 2^32: the source offset wraps after 256 words.
                write_reg(CFG_RANK, 4);
                write_reg(CFG_DIM0, 1);
                write_reg(CFG_DIM1, 4096);
                write_reg(CFG_DIM2, 4096);
                write_reg(CFG_DIM3, 4096);
                write_reg(CFG_AXIS_ORDER, 120);
            end
            else
            begin
                apply_random_config();
            end
            @(negedge clk);
            t_modes();
            if (phase_no == 3)
            begin
                @(posedge clk);
                long_hold_req = 1'b1;
            end
            if (phase_no == 1)
                run_words(280, 0);
            else
                run_words(40 + $urandom_range(0, 20) - 10,
                          ($urandom_range(0, 3) == 0) ? 30 : 5);
            words_sent += (phase_no == 1) ? 280 : 40;
            phase_no++;
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: sim.f
src/tta_pkg.sv
src/tta_skid.sv
src/tta_stride.sv
src/tensor_transpose_address_gen.sv
tb/transpose_addr_checker.sv
tb/tb_tensor_transpose_address_gen.sv
